FILE: rtl/pwsf_pkg.sv
// ----------------------------------------------------------------------------
// Pedestal window statistics: shared package
// Field widths, register codes, the command passed from the front end to the
// back end, and the back-end state encoding.
// ----------------------------------------------------------------------------
package pwsf_pkg;

    // Stream payload fields
    localparam int OP_W       = 2;
    localparam int CH_W       = 9;
    localparam int WIN_W      = 5;
    localparam int TS_W       = 16;
    localparam int TIME_W     = 40;
    localparam int IN_DATA_W  = 72;

    // Result fields
    localparam int ENTRIES_W  = 20;
    localparam int MEAN_W     = 16;
    localparam int RMS_W      = 16;
    localparam int OUT_DATA_W = 56;

    // Configuration
    localparam int SLICE_W    = 27;
    localparam int LIMIT_W    = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 27'd180000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd24;

    // Accumulator widths and arithmetic
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 56;
    localparam int VAL_W      = 15;     // accepted sums are positive and below 2^15
    localparam int ROOT_W     = 64;
    localparam int RANGE_STEP = 800;    // 50 samples of headroom in 1/16 units

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM = 2'd0,
        OP_TIME  = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        REG_SLICE_LENGTH = 1'b0,
        REG_WINDOW_LIMIT = 1'b1
    } t_reg;

    // Classified item handed from front to back
    typedef struct packed {
        t_op              op;
        logic             in_store;
        logic             acc_ok;     // accumulate passes window, limit and range checks
        logic             slice_end;
        logic [CH_W-1:0]  channel;
        logic [WIN_W-1:0] window;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV_MEAN,
        ST_DIV_VAR1,
        ST_DIV_VAR2,
        ST_SQRT,
        ST_EMIT
    } t_back_state;

endpackage

FILE: rtl/pwsf_queue.sv
// ----------------------------------------------------------------------------
// Pedestal window statistics: command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pwsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pwsf_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output pwsf_pkg::t_cmd  o_head
);

    pwsf_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    // Store pushed beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/pwsf_back.sv
// ----------------------------------------------------------------------------
// Pedestal window statistics: back end
// Holds the per-entry count, sum and sum of squares, performs the
// read-modify-write for accumulation and the iterative mean and rms for a
// drain, and drives the result register.
// ----------------------------------------------------------------------------
module pwsf_back #(
    parameter int NUM_CHANNELS = 512,
    parameter int NUM_WINDOWS  = 32,
    parameter int COUNT_BITS   = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  pwsf_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: slice_end, accepted, entries[19:0], mean_per_sample[15:0],
    //        rms[15:0], two zero bits
    output logic [pwsf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    localparam int DEPTH  = NUM_CHANNELS * NUM_WINDOWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MEM_W  = COUNT_BITS + pwsf_pkg::SUM_W + pwsf_pkg::SQ_W;
    localparam int D_W    = COUNT_BITS + pwsf_pkg::LIMIT_W;
    localparam int DVS_W  = D_W + 1;
    localparam int DIFF_W = COUNT_BITS + pwsf_pkg::SQ_W;
    localparam int MP_W   = (COUNT_BITS > pwsf_pkg::SUM_W) ? COUNT_BITS : pwsf_pkg::SUM_W;
    localparam int CNT_W  = $clog2(DIFF_W + 1);
    localparam int VSQ_W  = 2 * pwsf_pkg::VAL_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    pwsf_pkg::t_back_state r_state, n_state;

    // Storage and read path
    logic [MEM_W-1:0]  r_mem [DEPTH];
    logic [MEM_W-1:0]  r_rd_word;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] head_addr;
    pwsf_pkg::t_cmd    r_cmd;
    logic [VSQ_W-1:0]  r_vsq;

    logic [COUNT_BITS-1:0]         rd_count;
    logic [pwsf_pkg::SUM_W-1:0]    rd_sum;
    logic [pwsf_pkg::SQ_W-1:0]     rd_sq;

    // Arithmetic registers
    logic [COUNT_BITS-1:0]         r_n;
    logic [pwsf_pkg::SUM_W-1:0]    r_s;
    logic [D_W-1:0]                r_d;
    logic [DIFF_W-1:0]             r_acc;
    logic [DIFF_W-1:0]             r_mcand;
    logic [MP_W-1:0]               r_mplier;
    logic                          r_phase;
    logic [CNT_W-1:0]              r_cnt;
    logic [DIFF_W-1:0]             r_num;
    logic [DVS_W-1:0]              r_rem;
    logic [DVS_W-1:0]              r_dvs;
    logic [pwsf_pkg::ROOT_W-1:0]   r_x;
    logic [pwsf_pkg::ROOT_W-1:0]   r_root;
    logic [pwsf_pkg::ROOT_W-1:0]   r_bit;

    // Result registers
    logic                              r_res_slice;
    logic                              r_res_acc;
    logic [pwsf_pkg::ENTRIES_W-1:0]    r_entries;
    logic [pwsf_pkg::MEAN_W-1:0]       r_mean;
    logic [pwsf_pkg::RMS_W-1:0]        r_rms;
    logic                              r_o_valid;
    logic [pwsf_pkg::OUT_DATA_W-1:0]   r_o_data;

    // Control
    logic                   pop;
    logic                   out_free;
    logic                   out_load;
    logic                   acc_do;
    logic                   drain_hit;
    logic                   drain_live;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]       mem_wdata;
    logic [pwsf_pkg::OUT_DATA_W-1:0] out_next;

    // Step datapaths
    logic [DVS_W:0]                rem_sh;
    logic                          div_ge;
    logic [DVS_W-1:0]              rem_next;
    logic [DIFF_W-1:0]             q_next;
    logic [pwsf_pkg::ROOT_W-1:0]   trial;
    logic                          root_fits;
    logic [pwsf_pkg::ROOT_W-1:0]   root_next;

    assign head_addr = ADDR_W'(int'(i_cmd.channel) * NUM_WINDOWS + int'(i_cmd.window));
    assign rd_count  = r_rd_word[COUNT_BITS-1:0];
    assign rd_sum    = r_rd_word[COUNT_BITS +: pwsf_pkg::SUM_W];
    assign rd_sq     = r_rd_word[COUNT_BITS + pwsf_pkg::SUM_W +: pwsf_pkg::SQ_W];

    assign acc_do     = (r_cmd.op == pwsf_pkg::OP_ACCUM) && r_cmd.acc_ok
                        && (rd_count != COUNT_MAX);
    assign drain_hit  = (r_cmd.op == pwsf_pkg::OP_DRAIN) && r_cmd.in_store;
    assign drain_live = drain_hit && (rd_count != '0);
    assign out_free   = !r_o_valid || i_m_axis_tready;

    // Restoring divide step
    assign rem_sh   = {r_rem, r_num[DIFF_W-1]};
    assign div_ge   = (rem_sh >= {1'b0, r_dvs});
    assign rem_next = div_ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
    assign q_next   = {r_num[DIFF_W-2:0], div_ge};

    // Digit-by-digit square root step
    assign trial     = r_root + r_bit;
    assign root_fits = (r_x >= trial);
    assign root_next = root_fits ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pwsf_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = pwsf_pkg::ST_IDLE;
                end
            end
            pwsf_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = pwsf_pkg::ST_READ;
                end
            end
            pwsf_pkg::ST_READ: begin
                if (drain_live) begin
                    n_state = pwsf_pkg::ST_MUL;
                end else if (out_free) begin
                    n_state = pwsf_pkg::ST_IDLE;
                end else begin
                    n_state = pwsf_pkg::ST_EMIT;
                end
            end
            pwsf_pkg::ST_MUL: begin
                if (r_cnt == '0 && r_phase) begin
                    n_state = pwsf_pkg::ST_DIV_MEAN;
                end
            end
            pwsf_pkg::ST_DIV_MEAN: begin
                if (r_cnt == '0) begin
                    n_state = pwsf_pkg::ST_DIV_VAR1;
                end
            end
            pwsf_pkg::ST_DIV_VAR1: begin
                if (r_cnt == '0) begin
                    n_state = pwsf_pkg::ST_DIV_VAR2;
                end
            end
            pwsf_pkg::ST_DIV_VAR2: begin
                if (r_cnt == '0) begin
                    n_state = pwsf_pkg::ST_SQRT;
                end
            end
            pwsf_pkg::ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = pwsf_pkg::ST_EMIT;
                end
            end
            pwsf_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = pwsf_pkg::ST_IDLE;
                end
            end
            default: n_state = pwsf_pkg::ST_IDLE;
        endcase
    end

    // Control outputs per state
    always_comb begin
        pop       = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        out_next  = {2'b00, r_rms, r_mean, r_entries, r_res_acc, r_res_slice};
        unique case (r_state)
            pwsf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            pwsf_pkg::ST_IDLE: begin
                pop = i_q_valid;
            end
            pwsf_pkg::ST_READ: begin
                mem_we   = acc_do || drain_hit;
                if (acc_do) begin
                    mem_wdata = {rd_sq + pwsf_pkg::SQ_W'(r_vsq),
                                 rd_sum + pwsf_pkg::SUM_W'(r_cmd.value),
                                 rd_count + COUNT_BITS'(1)};
                end
                out_load = !drain_live && out_free;
                out_next = {2'b00, pwsf_pkg::RMS_W'(0), pwsf_pkg::MEAN_W'(0),
                            pwsf_pkg::ENTRIES_W'(0), acc_do,
                            (r_cmd.op == pwsf_pkg::OP_TIME) && r_cmd.slice_end};
            end
            pwsf_pkg::ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            r_rd_word <= r_mem[head_addr];
        end
    end

    // State, clear sweep and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pwsf_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pwsf_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_data <= out_next;
        end
    end

    // Datapath: latch command, multiply, divide, square root
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pwsf_pkg::ST_IDLE: begin
                if (pop) begin
                    r_cmd  <= i_cmd;
                    r_addr <= head_addr;
                    r_vsq  <= VSQ_W'(i_cmd.value) * VSQ_W'(i_cmd.value);
                end
            end
            pwsf_pkg::ST_READ: begin
                r_res_slice <= (r_cmd.op == pwsf_pkg::OP_TIME) && r_cmd.slice_end;
                r_res_acc   <= acc_do;
                r_entries   <= drain_live ? pwsf_pkg::ENTRIES_W'(rd_count) : '0;
                r_mean      <= '0;
                r_rms       <= '0;
                r_n         <= rd_count;
                r_s         <= rd_sum;
                r_d         <= D_W'(rd_count) * D_W'({1'b0, r_cmd.window} + 6'd1);
                r_acc       <= '0;
                r_mcand     <= DIFF_W'(rd_sq);
                r_mplier    <= MP_W'(rd_count);
                r_phase     <= 1'b0;
                r_cnt       <= CNT_W'(COUNT_BITS - 1);
            end
            pwsf_pkg::ST_MUL: begin
                // add n*sq first, then subtract s*s, one multiplier bit a cycle
                if (r_mplier[0]) begin
                    r_acc <= r_phase ? (r_acc - r_mcand) : (r_acc + r_mcand);
                end
                if (r_cnt != '0) begin
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_W'(1);
                end else if (!r_phase) begin
                    r_mcand  <= DIFF_W'(r_s);
                    r_mplier <= MP_W'(r_s);
                    r_cnt    <= CNT_W'(pwsf_pkg::SUM_W - 1);
                    r_phase  <= 1'b1;
                end else begin
                    // rounded mean: (2s + d) / 2d
                    r_num <= DIFF_W'({r_s, 1'b0}) + DIFF_W'(r_d);
                    r_dvs <= DVS_W'({r_d, 1'b0});
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIFF_W - 1);
                end
            end
            pwsf_pkg::ST_DIV_MEAN, pwsf_pkg::ST_DIV_VAR1, pwsf_pkg::ST_DIV_VAR2: begin
                if (r_cnt != '0) begin
                    r_rem <= rem_next;
                    r_num <= q_next;
                    r_cnt <= r_cnt - CNT_W'(1);
                end else if (r_state == pwsf_pkg::ST_DIV_MEAN) begin
                    r_mean <= pwsf_pkg::MEAN_W'(q_next);
                    r_num  <= r_acc;
                    r_dvs  <= DVS_W'(r_n);
                    r_rem  <= '0;
                    r_cnt  <= CNT_W'(DIFF_W - 1);
                end else if (r_state == pwsf_pkg::ST_DIV_VAR1) begin
                    r_num <= q_next;
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIFF_W - 1);
                end else begin
                    r_x    <= q_next[pwsf_pkg::ROOT_W-1:0];
                    r_root <= '0;
                    r_bit  <= pwsf_pkg::ROOT_W'(1) << (pwsf_pkg::ROOT_W - 2);
                    r_cnt  <= CNT_W'(pwsf_pkg::ROOT_W / 2 - 1);
                end
            end
            pwsf_pkg::ST_SQRT: begin
                r_x    <= root_fits ? (r_x - trial) : r_x;
                r_root <= root_next;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_rms <= pwsf_pkg::RMS_W'(root_next);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_pop           = pop;
    assign o_clearing      = (r_state == pwsf_pkg::ST_CLEAR);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    // A result appears only out of the read or the emit step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |->
            ($past(r_state) == pwsf_pkg::ST_READ || $past(r_state) == pwsf_pkg::ST_EMIT))
        else $error("result register loaded outside read or emit");

    // The root probe bit walks as a single bit
    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwsf_pkg::ST_SQRT) |-> $onehot(r_bit))
        else $error("square root probe bit lost");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwsf_pkg::ST_DIV_MEAN || r_state == pwsf_pkg::ST_DIV_VAR1
         || r_state == pwsf_pkg::ST_DIV_VAR2) |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

    // Nothing leaves the queue while the store is swept
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pwsf_pkg::ST_CLEAR) |=> (r_state != pwsf_pkg::ST_READ))
        else $error("item taken during clear sweep");

endmodule

FILE: rtl/pwsf_front.sv
// ----------------------------------------------------------------------------
// Pedestal window statistics: front end
// Takes input beats, holds the configuration registers and the time-slice
// start, classifies each item and pushes a command to the queue.
// ----------------------------------------------------------------------------
module pwsf_front #(
    parameter int NUM_CHANNELS = 512,
    parameter int NUM_WINDOWS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwsf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pwsf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pwsf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: channel[8:0], window[4:0], trace_sum[15:0], event_time_ms[39:0],
    //        two zero bits
    input  logic [pwsf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [pwsf_pkg::OP_W-1:0]           i_s_axis_tuser,
    input  logic                                i_hold,
    input  logic                                i_q_full,
    output logic                                o_push,
    output pwsf_pkg::t_cmd                      o_cmd
);

    logic [pwsf_pkg::SLICE_W-1:0] r_slice_length;
    logic [pwsf_pkg::LIMIT_W-1:0] r_window_limit;
    logic [pwsf_pkg::TIME_W-1:0]  r_slice_start;

    pwsf_pkg::t_op                op;
    logic [pwsf_pkg::CH_W-1:0]    channel;
    logic [pwsf_pkg::WIN_W-1:0]   window;
    logic [pwsf_pkg::TS_W-1:0]    trace_sum;
    logic [pwsf_pkg::TIME_W-1:0]  event_time;
    logic [pwsf_pkg::TIME_W-1:0]  elapsed;
    logic [pwsf_pkg::VAL_W-1:0]   range_lim;
    logic                         in_store;
    logic                         in_range;
    logic                         slice_end;
    logic                         accept;
    logic                         cfg_wr;

    // Unpack the beat
    assign op         = pwsf_pkg::t_op'(i_s_axis_tuser);
    assign channel    = i_s_axis_tdata[8:0];
    assign window     = i_s_axis_tdata[13:9];
    assign trace_sum  = i_s_axis_tdata[29:14];
    assign event_time = i_s_axis_tdata[69:30];

    assign o_s_axis_tready = !i_hold && !i_q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Classify: store bounds, window limit and open sum range
    assign in_store  = (int'(channel) < NUM_CHANNELS) && (int'(window) < NUM_WINDOWS);
    assign range_lim = pwsf_pkg::VAL_W'(pwsf_pkg::RANGE_STEP * (int'(window) + 1));
    assign in_range  = !trace_sum[pwsf_pkg::TS_W-1] && (trace_sum != '0)
                       && (trace_sum[pwsf_pkg::VAL_W-1:0] < range_lim);

    // Slice ends when time moves forward by more than the slice length
    assign elapsed   = event_time - r_slice_start;
    assign slice_end = (op == pwsf_pkg::OP_TIME) && (r_slice_start != '0)
                       && (event_time > r_slice_start)
                       && (elapsed > pwsf_pkg::TIME_W'(r_slice_length));

    assign o_push            = accept;
    assign o_cmd.op          = op;
    assign o_cmd.in_store    = in_store;
    assign o_cmd.acc_ok      = in_store && in_range
                               && ({1'b0, window} < r_window_limit);
    assign o_cmd.slice_end   = slice_end;
    assign o_cmd.channel     = channel;
    assign o_cmd.window      = window;
    assign o_cmd.value       = trace_sum[pwsf_pkg::VAL_W-1:0];

    // Configuration read and write
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (pwsf_pkg::t_reg'(paddr[2]))
            pwsf_pkg::REG_SLICE_LENGTH: prdata = pwsf_pkg::APB_DATA_W'(r_slice_length);
            pwsf_pkg::REG_WINDOW_LIMIT: prdata = pwsf_pkg::APB_DATA_W'(r_window_limit);
            default:                    prdata = '0;
        endcase
    end

    // Hold registers and slice start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_length <= pwsf_pkg::SLICE_RESET;
            r_window_limit <= pwsf_pkg::LIMIT_RESET;
            r_slice_start  <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (pwsf_pkg::t_reg'(paddr[2]))
                    pwsf_pkg::REG_SLICE_LENGTH:
                        r_slice_length <= pwdata[pwsf_pkg::SLICE_W-1:0];
                    pwsf_pkg::REG_WINDOW_LIMIT:
                        r_window_limit <= pwdata[pwsf_pkg::LIMIT_W-1:0];
                    default: r_window_limit <= r_window_limit;
                endcase
            end
            if (accept && (op == pwsf_pkg::OP_TIME)
                    && ((r_slice_start == '0) || slice_end)) begin
                r_slice_start <= event_time;
            end
        end
    end

endmodule

FILE: rtl/pedestal_window_statistics.sv
// Accumulate, event-time and empty drain beats reach the output through the command queue,
// the store read and the result register. A drain of a filled entry runs through the shift-add
// multiplier, three divider passes and the root unit before its result is loaded.
// The back end takes a new item only after the store read-modify-write of the last one.
// Reset is synchronous; afterwards a clearing pass over all NUM_CHANNELS*NUM_WINDOWS entries
// (16384 by default) zeroes the store while no item is accepted; configuration stays open.
// ----------------------------------------------------------------------------
// Pedestal window statistics: top level
// Per channel and window running count, sum and sum of squares of pedestal
// trace sums, with slice tracking and drain of mean and rms.
// ----------------------------------------------------------------------------
module pedestal_window_statistics #(
    parameter int NUM_CHANNELS = 512,
    parameter int NUM_WINDOWS  = 32,
    parameter int COUNT_BITS   = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwsf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pwsf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pwsf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: channel[8:0], window[4:0], trace_sum[15:0], event_time_ms[39:0],
    //        two zero bits
    input  logic [pwsf_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [pwsf_pkg::OP_W-1:0]           i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: slice_end, accepted, entries[19:0], mean_per_sample[15:0],
    //        rms[15:0], two zero bits
    output logic [pwsf_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    logic           clearing;
    pwsf_pkg::t_cmd cmd_in;
    pwsf_pkg::t_cmd cmd_head;

    pwsf_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_WINDOWS  (NUM_WINDOWS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_hold          (clearing),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (cmd_in)
    );

    pwsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (cmd_head)
    );

    pwsf_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_WINDOWS  (NUM_WINDOWS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (cmd_head),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
